// ===== sv/quaternion_to_euler_angles_unit_defines.svh =====
// Assertion macros shared by the quaternion to Euler angles unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QTE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/qte_pkg.sv =====
// Shared constants, types and the arctangent table of the quaternion to Euler unit.
// No dependencies; used by qte_cordic and quaternion_to_euler_angles_unit.
package qte_pkg;

	localparam int COMPONENT_WIDTH_DEF   = 16;
	localparam int CORDIC_ITERATIONS_DEF = 16;

	// Datapath widths.
	localparam int QW = 17;  // component after range reduction
	localparam int PW = 32;  // one product of two components
	localparam int SW = 34;  // sums of products
	localparam int XW = 38;  // CORDIC x and y
	localparam int ZW = 35;  // CORDIC angle, radians with 30 fraction bits
	localparam int OUT_W = 48;

	localparam int AtanEntries = 30;

	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic [28:0] DEG_PER_RAD_Q23 = 29'd480631834;
	localparam logic signed [15:0] ROLL_LIMIT = 16'sd23040;
	localparam logic signed [14:0] PITCH_LIMIT = 15'sd11520;

	localparam logic [29:0] ATAN_TAB [AtanEntries] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};

	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
		logic signed [ZW-1:0] res;
		res = '0;
		if (idx < 5'(AtanEntries)) begin
			res = ZW'(ATAN_TAB[idx]);
		end
		return res;
	endfunction

	// Special-case flags that travel alongside the CORDIC lanes.
	typedef struct packed {
		logic zero;
		logic rn_zero;
		logic rd_neg;
		logic yn_zero;
		logic yd_neg;
		logic pn_zero;
		logic pn_neg;
	} qte_flags_t;

	typedef struct packed {
		qte_flags_t           flags;
		logic signed [ZW-1:0] roll_z;
		logic signed [ZW-1:0] yaw_z;
	} qte_side_t;

	typedef struct packed {
		logic                 zero;
		logic signed [15:0]   yaw;
		logic signed [14:0]   pitch;
		logic signed [15:0]   roll;
	} qte_result_t;

endpackage

// ===== sv/qte_cordic.sv =====
// Pipelined vectoring CORDIC: several parallel lanes, one register stage per iteration.
// Depends on qte_pkg for widths and the arctangent table.
module qte_cordic import qte_pkg::*; #(
	parameter int ITERATIONS = CORDIC_ITERATIONS_DEF,
	parameter int LANES      = 1,
	parameter int SIDE_W     = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [XW-1:0]     x_in [LANES],
	input  logic signed [XW-1:0]     y_in [LANES],
	input  logic [SIDE_W-1:0]        side_in,
	output logic                     out_valid,
	output logic signed [XW-1:0]     x_out [LANES],
	output logic signed [ZW-1:0]     z_out [LANES],
	output logic [SIDE_W-1:0]        side_out
);

	logic                 v_s    [ITERATIONS+1];
	logic signed [XW-1:0] x_s    [ITERATIONS+1][LANES];
	logic signed [XW-1:0] y_s    [ITERATIONS][LANES];
	logic signed [ZW-1:0] z_s    [ITERATIONS+1][LANES];
	logic [SIDE_W-1:0]    side_s [ITERATIONS+1];

	// Stage 0 folds the left half plane onto the right and seeds the angle with +-pi.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int l = 0; l < LANES; l++) begin
				if (x_in[l][XW-1]) begin
					x_s[0][l] <= -x_in[l];
					y_s[0][l] <= -y_in[l];
					z_s[0][l] <= y_in[l][XW-1] ? -PI_Q30 : PI_Q30;
				end else begin
					x_s[0][l] <= x_in[l];
					y_s[0][l] <= y_in[l];
					z_s[0][l] <= '0;
				end
			end
		end
	end

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
		localparam logic signed [ZW-1:0] AtanStep = atan_q30(5'(i));

		logic signed [XW-1:0] nx [LANES];
		logic signed [XW-1:0] ny [LANES];
		logic signed [ZW-1:0] nz [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				if (!y_s[i][l][XW-1] && (y_s[i][l] != '0)) begin
					nx[l] = x_s[i][l] + (y_s[i][l] >>> i);
					ny[l] = y_s[i][l] - (x_s[i][l] >>> i);
					nz[l] = z_s[i][l] + AtanStep;
				end else begin
					nx[l] = x_s[i][l] - (y_s[i][l] >>> i);
					ny[l] = y_s[i][l] + (x_s[i][l] >>> i);
					nz[l] = z_s[i][l] - AtanStep;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				for (int l = 0; l < LANES; l++) begin
					x_s[i+1][l] <= nx[l];
					z_s[i+1][l] <= nz[l];
				end
			end
		end

		if (i + 1 < ITERATIONS) begin : g_y
			always_ff @(posedge clk) begin
				if (en) begin
					for (int l = 0; l < LANES; l++) begin
						y_s[i+1][l] <= ny[l];
					end
				end
			end
		end
	end

	assign out_valid = v_s[ITERATIONS];
	assign x_out     = x_s[ITERATIONS];
	assign z_out     = z_s[ITERATIONS];
	assign side_out  = side_s[ITERATIONS];

endmodule

// ===== sv/quaternion_to_euler_angles_unit.sv =====
// Top level of the quaternion to ZYX Euler angles unit (roll, pitch, yaw in degrees).
// Depends on qte_pkg, qte_cordic and quaternion_to_euler_angles_unit_defines.svh.
//
// Usage:
//   The input stream carries one raw quaternion per word: s_axis_tdata holds w, x, y, z
//   as signed Q2.14 values (COMPONENT_WIDTH bits each), w in the lowest bits. The length
//   of the quaternion does not matter; normalization is folded into the ratios that feed
//   the angle computations.
//   The output stream carries one word per input word, in order: roll, pitch and yaw in
//   degrees with 7 fraction bits, and m_axis_tuser flags a zero-length input, for which
//   all three angles are zero.
//   Throughput is one word per cycle while the pipeline is not frozen: the datapath is a
//   fixed pipeline of six front stages, two chains of CORDIC_ITERATIONS+1 CORDIC stages
//   and two stages of degree conversion, feeding a two-entry output register.
//   When the receiver stalls, the output register holds its word and a skid entry takes
//   one more; only when the skid entry is full does the whole pipeline freeze and
//   s_axis_tready drop, so no word is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
`include "quaternion_to_euler_angles_unit_defines.svh"

module quaternion_to_euler_angles_unit import qte_pkg::*; #(
	parameter int COMPONENT_WIDTH   = COMPONENT_WIDTH_DEF,
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// quat_w, quat_x, quat_y, quat_z from the lowest bit up, zero padding on top
	input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// roll_deg [15:0], pitch_deg [30:16], yaw_deg [46:31], bit 47 always zero
	output logic [OUT_W-1:0]                          m_axis_tdata,
	// zero_norm
	output logic                                      m_axis_tuser
);

	// Extended width that can hold the magnitude of any component.
	localparam int EW    = (COMPONENT_WIDTH + 1 > QW) ? COMPONENT_WIDTH + 1 : QW;
	localparam int MAXSH = EW - QW;

	// The whole pipeline moves together; it stops only while the skid entry is full.
	logic en;
	logic skid_v_q, main_v_q;
	qte_result_t skid_q, main_q;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	// Stage 1: sign extension and largest magnitude.
	logic signed [EW-1:0] ce [4];
	logic [EW-1:0]        ca [4];
	logic [EW-1:0]        cmax;
	logic                 v_s1;
	logic signed [EW-1:0] c_s1 [4];
	logic [EW-1:0]        m_s1;

	always_comb begin
		cmax = '0;
		for (int k = 0; k < 4; k++) begin
			ce[k] = EW'($signed(s_axis_tdata[k*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
			ca[k] = ce[k][EW-1] ? EW'(-ce[k]) : EW'(ce[k]);
			if (ca[k] > cmax) begin
				cmax = ca[k];
			end
		end
	end

	// Stage 2: wide components are shifted down together until they fit 17 bits.
	logic [5:0]           sh;
	logic                 v_s2;
	logic signed [QW-1:0] q_s2 [4];

	always_comb begin
		sh = '0;
		for (int s = MAXSH; s >= 0; s--) begin
			if ((m_s1 >> s) <= EW'(32768)) begin
				sh = 6'(s);
			end
		end
	end

	// Stage 3: the ten products.
	logic v_s3;
	logic signed [PW-1:0] sqw_s3, sqx_s3, sqy_s3, sqz_s3;
	logic signed [PW-1:0] pwx_s3, pyz_s3, pwy_s3, pzx_s3, pwz_s3, pxy_s3;

	// Stage 4: length squared and the five numerators and denominators.
	logic v_s4, zero_s4;
	logic signed [SW-1:0] sum_s4, rn_s4, rd_s4, pn_s4, yn_s4, yd_s4;

	// Stage 5: shift count that brings the length squared into [2^32, 2^33).
	logic [5:0] msb, nsh;
	logic v_s5;
	logic [5:0] nsh_s5;
	qte_flags_t flags_s5;
	logic signed [SW-1:0] rn_s5, rd_s5, pn_s5, yn_s5, yd_s5;

	always_comb begin
		msb = '0;
		for (int b = 0; b <= 32; b++) begin
			if (sum_s4[b]) begin
				msb = 6'(b);
			end
		end
		nsh = 6'd32 - msb;
	end

	// Stage 6: common scaling; feeds the first CORDIC chain.
	logic signed [XW-1:0] pn_x;
	logic v_s6;
	qte_flags_t flags_s6;
	logic signed [XW-1:0] rn_s6, rd_s6, yn_s6, yd_s6, pa_s6;

	assign pn_x = XW'(pn_s5) <<< nsh_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= ce;
			m_s1 <= cmax;

			for (int k = 0; k < 4; k++) begin
				q_s2[k] <= QW'(c_s1[k] >>> sh);
			end

			sqw_s3 <= PW'(q_s2[0] * q_s2[0]);
			sqx_s3 <= PW'(q_s2[1] * q_s2[1]);
			sqy_s3 <= PW'(q_s2[2] * q_s2[2]);
			sqz_s3 <= PW'(q_s2[3] * q_s2[3]);
			pwx_s3 <= PW'(q_s2[0] * q_s2[1]);
			pyz_s3 <= PW'(q_s2[2] * q_s2[3]);
			pwy_s3 <= PW'(q_s2[0] * q_s2[2]);
			pzx_s3 <= PW'(q_s2[3] * q_s2[1]);
			pwz_s3 <= PW'(q_s2[0] * q_s2[3]);
			pxy_s3 <= PW'(q_s2[1] * q_s2[2]);

			sum_s4  <= SW'(sqw_s3) + SW'(sqx_s3) + SW'(sqy_s3) + SW'(sqz_s3);
			zero_s4 <= (sqw_s3 == '0) && (sqx_s3 == '0) && (sqy_s3 == '0) && (sqz_s3 == '0);
			rn_s4   <= (SW'(pwx_s3) + SW'(pyz_s3)) <<< 1;
			rd_s4   <= SW'(sqw_s3) - SW'(sqx_s3) - SW'(sqy_s3) + SW'(sqz_s3);
			pn_s4   <= (SW'(pwy_s3) - SW'(pzx_s3)) <<< 1;
			yn_s4   <= (SW'(pwz_s3) + SW'(pxy_s3)) <<< 1;
			yd_s4   <= SW'(sqw_s3) + SW'(sqx_s3) - SW'(sqy_s3) - SW'(sqz_s3);

			nsh_s5           <= nsh;
			flags_s5.zero    <= zero_s4;
			flags_s5.rn_zero <= (rn_s4 == '0);
			flags_s5.rd_neg  <= rd_s4[SW-1];
			flags_s5.yn_zero <= (yn_s4 == '0);
			flags_s5.yd_neg  <= yd_s4[SW-1];
			flags_s5.pn_zero <= (pn_s4 == '0);
			flags_s5.pn_neg  <= pn_s4[SW-1];
			rn_s5 <= rn_s4;
			rd_s5 <= rd_s4;
			pn_s5 <= pn_s4;
			yn_s5 <= yn_s4;
			yd_s5 <= yd_s4;

			flags_s6 <= flags_s5;
			rn_s6    <= XW'(rn_s5) <<< nsh_s5;
			rd_s6    <= XW'(rd_s5) <<< nsh_s5;
			yn_s6    <= XW'(yn_s5) <<< nsh_s5;
			yd_s6    <= XW'(yd_s5) <<< nsh_s5;
			pa_s6    <= pn_x[XW-1] ? -pn_x : pn_x;
		end
	end

	// First CORDIC chain: lane 0 roll, lane 1 yaw, lane 2 scaled pitch numerator.
	logic signed [XW-1:0] p1_xi [3];
	logic signed [XW-1:0] p1_yi [3];
	logic signed [XW-1:0] p1_xo [3];
	logic signed [ZW-1:0] p1_zo [3];
	logic                 p1_v;
	qte_flags_t           p1_flags;

	assign p1_xi[0] = rd_s6;
	assign p1_yi[0] = rn_s6;
	assign p1_xi[1] = yd_s6;
	assign p1_yi[1] = yn_s6;
	assign p1_xi[2] = pa_s6;
	assign p1_yi[2] = '0;

	qte_cordic #(
		.ITERATIONS (CORDIC_ITERATIONS),
		.LANES      (3),
		.SIDE_W     ($bits(qte_flags_t))
	) u_cordic_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.x_in      (p1_xi),
		.y_in      (p1_yi),
		.side_in   (flags_s6),
		.out_valid (p1_v),
		.x_out     (p1_xo),
		.z_out     (p1_zo),
		.side_out  (p1_flags)
	);

	// Second CORDIC chain: pitch from the roll magnitude and the pitch numerator magnitude.
	logic signed [XW-1:0] p2_xi [1];
	logic signed [XW-1:0] p2_yi [1];
	logic signed [ZW-1:0] p2_zo [1];
	logic                 p2_v;
	qte_side_t            p1_side, p2_side;

	assign p2_xi[0]       = p1_xo[0];
	assign p2_yi[0]       = p1_xo[2];
	assign p1_side.flags  = p1_flags;
	assign p1_side.roll_z = p1_zo[0];
	assign p1_side.yaw_z  = p1_zo[1];

	qte_cordic #(
		.ITERATIONS (CORDIC_ITERATIONS),
		.LANES      (1),
		.SIDE_W     ($bits(qte_side_t))
	) u_cordic_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (p1_v),
		.x_in      (p2_xi),
		.y_in      (p2_yi),
		.side_in   (p1_side),
		.out_valid (p2_v),
		.x_out     (),
		.z_out     (p2_zo),
		.side_out  (p2_side)
	);

	// Stage 7: special cases, then radians to degrees by one multiply per angle.
	logic signed [ZW-1:0] roll_zf, yaw_zf, pitch_zf;
	logic [ZW-1:0]        roll_ua, yaw_ua, pitch_ua;
	logic                 v_s7, zero_s7, rneg_s7, yneg_s7, pneg_s7;
	logic [60:0]          rprod_s7, yprod_s7, pprod_s7;

	always_comb begin
		// A zero numerator gives exactly zero, or pi when the denominator is negative.
		roll_zf = p2_side.flags.rn_zero ? (p2_side.flags.rd_neg ? PI_Q30 : '0) : p2_side.roll_z;
		yaw_zf  = p2_side.flags.yn_zero ? (p2_side.flags.yd_neg ? PI_Q30 : '0) : p2_side.yaw_z;
		pitch_zf = p2_side.flags.pn_zero ? '0 : p2_zo[0];
		roll_ua  = roll_zf[ZW-1]  ? ZW'(-roll_zf)  : ZW'(roll_zf);
		yaw_ua   = yaw_zf[ZW-1]   ? ZW'(-yaw_zf)   : ZW'(yaw_zf);
		pitch_ua = pitch_zf[ZW-1] ? ZW'(-pitch_zf) : ZW'(pitch_zf);
	end

	// Stage 8: rounding half away from zero, saturation and sign.
	logic [61:0] rsum, ysum, psum;
	logic [15:0] rmag, ymag, pmag, rsat, ysat, psat;
	logic v_s8;
	qte_result_t res_s8;

	always_comb begin
		rsum = {1'b0, rprod_s7} + (62'd1 << 45);
		ysum = {1'b0, yprod_s7} + (62'd1 << 45);
		psum = {1'b0, pprod_s7} + (62'd1 << 45);
		rmag = rsum[61:46];
		ymag = ysum[61:46];
		pmag = psum[61:46];
		rsat = (rmag > 16'(ROLL_LIMIT))  ? 16'(ROLL_LIMIT)  : rmag;
		ysat = (ymag > 16'(ROLL_LIMIT))  ? 16'(ROLL_LIMIT)  : ymag;
		psat = (pmag > 16'(PITCH_LIMIT)) ? 16'(PITCH_LIMIT) : pmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s7 <= p2_v;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s7  <= p2_side.flags.zero;
			rneg_s7  <= roll_zf[ZW-1];
			yneg_s7  <= yaw_zf[ZW-1];
			pneg_s7  <= pitch_zf[ZW-1] ^ p2_side.flags.pn_neg;
			rprod_s7 <= {29'd0, roll_ua[31:0]}  * {32'd0, DEG_PER_RAD_Q23};
			yprod_s7 <= {29'd0, yaw_ua[31:0]}   * {32'd0, DEG_PER_RAD_Q23};
			pprod_s7 <= {29'd0, pitch_ua[31:0]} * {32'd0, DEG_PER_RAD_Q23};

			res_s8.zero <= zero_s7;
			if (zero_s7) begin
				res_s8.roll  <= '0;
				res_s8.pitch <= '0;
				res_s8.yaw   <= '0;
			end else begin
				res_s8.roll  <= rneg_s7 ? -$signed(rsat) : $signed(rsat);
				res_s8.yaw   <= yneg_s7 ? -$signed(ysat) : $signed(ysat);
				res_s8.pitch <= pneg_s7 ? -$signed(psat[14:0]) : $signed(psat[14:0]);
			end
		end
	end

	// Output register with one skid entry behind it.
	logic push, pop;

	assign push = en && v_s8;
	assign pop  = main_v_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= res_s8;
			end else begin
				main_q <= res_s8;
			end
		end
	end

	assign m_axis_tvalid = main_v_q;
	assign m_axis_tdata  = {1'b0, main_q.yaw, main_q.pitch, main_q.roll};
	assign m_axis_tuser  = main_q.zero;

	`QTE_ASSERT_NOW(a_skid_behind_main, skid_v_q, main_v_q, "skid entry full while output register empty")
	`QTE_ASSERT_NOW(a_skid_fills_on_stall, $rose(skid_v_q), $past(m_axis_tvalid) && !$past(m_axis_tready), "skid entry filled without a stalled output")
	`QTE_ASSERT_NOW(a_zero_gives_level, m_axis_tvalid && m_axis_tuser, m_axis_tdata[46:0] == '0, "zero-length word with nonzero angles")
	`QTE_ASSERT_NOW(a_pitch_range, m_axis_tvalid, ($signed(m_axis_tdata[30:16]) <= PITCH_LIMIT) && ($signed(m_axis_tdata[30:16]) >= -PITCH_LIMIT), "pitch outside plus or minus ninety degrees")
	`QTE_ASSERT_NEXT(a_frozen_holds_out, skid_v_q && !m_axis_tready, m_axis_tvalid, "output lost while pipeline frozen")

endmodule
